// File: rtl/bounded_queue_with_remove_defines.svh
// Assertion helpers for the checker file.
`ifndef BOUNDED_QUEUE_WITH_REMOVE_DEFINES_SVH
`define BOUNDED_QUEUE_WITH_REMOVE_DEFINES_SVH

// Same-cycle implication, sampled on clk, ignored while in reset.
`define BQR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bqr checker: property failed");

// Next-cycle implication, sampled on clk, ignored while in reset.
`define BQR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bqr checker: property failed");

`endif

// File: rtl/bqr_pkg.sv
package bqr_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W   = $clog2(DEPTH + 1);
  localparam int HANDLE_W = 32;
  localparam int CAP_W    = 5;
  localparam int MODE_W   = 2;
  localparam int CMP_W    = (CAP_W > FILL_W) ? CAP_W : FILL_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_FETCH  = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic                ins_en;
    logic                shift_en;
    logic                rem_en;
    logic [HANDLE_W-1:0] handle;
    logic [FILL_W-1:0]   fill;
  } cell_cmd_t;

endpackage

// File: rtl/bqr_if.sv
interface bqr_req_if;
  import bqr_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, output mode, output handle, input ready);
  modport sink   (input valid, input mode, input handle, output ready);
endinterface

interface bqr_rsp_if;
  import bqr_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [HANDLE_W-1:0] fetched;
  logic [FILL_W-1:0]   fill;

  modport source (output valid, output status, output fetched, output fill, input ready);
  modport sink   (input valid, input status, input fetched, input fill, output ready);
endinterface

// File: rtl/bqr_cell.sv
module bqr_cell (
  input  logic                          clk,
  input  bqr_pkg::cell_cmd_t            cmd_i,
  input  logic [bqr_pkg::IDX_W-1:0]     idx_i,
  input  logic [bqr_pkg::HANDLE_W-1:0]  nbr_i,
  input  logic                          hit_i,
  output logic [bqr_pkg::HANDLE_W-1:0]  data_o,
  output logic                          hit_o
);
  import bqr_pkg::*;

  logic [HANDLE_W-1:0] data_r;
  logic                held;
  logic                match;

  // Cell holds a live entry when its position lies below the fill.
  assign held   = FILL_W'(idx_i) < cmd_i.fill;
  assign match  = cmd_i.rem_en & held & (data_r == cmd_i.handle);
  assign hit_o  = hit_i | match;
  assign data_o = data_r;

  // Fetch shifts in from the neighbour, remove from the matching cell onwards; insert loads at the fill.
  always_ff @(posedge clk) begin
    priority if (cmd_i.shift_en || (cmd_i.rem_en && hit_o)) begin
      data_r <= nbr_i;
    end else if (cmd_i.ins_en && (FILL_W'(idx_i) == cmd_i.fill)) begin
      data_r <= cmd_i.handle;
    end else begin
      data_r <= data_r;
    end
  end

endmodule

// File: rtl/bounded_queue_with_remove.sv
// A result appears in the output register in the cycle after its request is accepted.
// Throughput: one request per cycle while the output is not stalled; every cell compares
//   and shifts in that cycle, with the match ripple along the row of DEPTH cells as the longest path.
// A new request is taken while a result waits, as long as the output register frees up.
// Reset (rst_n low, synchronous): fill to zero, output empty, capacity to 16.
//   Entry storage is not cleared; only entries below the fill are ever read.
module bounded_queue_with_remove (
  input  logic                        clk,
  input  logic                        rst_n,
  bqr_req_if.sink                     in_chan,
  bqr_rsp_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic [bqr_pkg::CAP_W-1:0]   cfg_wdata
);
  import bqr_pkg::*;

  // Queue state: position 0 of the cell row is always the head.
  logic [FILL_W-1:0]   fill_r;
  logic [FILL_W-1:0]   fill_nxt;
  logic [CAP_W-1:0]    cap_r;

  // Output register.
  logic                out_valid_r;
  status_t             out_status_r;
  logic [HANDLE_W-1:0] out_fetched_r;
  logic [FILL_W-1:0]   out_fill_r;

  logic                accept;
  logic [CMP_W-1:0]    limit;
  logic                can_ins;
  logic                not_empty;
  logic                found;
  status_t             status_nxt;
  logic [HANDLE_W-1:0] fetched_nxt;
  cell_cmd_t           cmd;

  logic [HANDLE_W-1:0] cell_data [DEPTH];
  logic [HANDLE_W-1:0] cell_nbr  [DEPTH];
  logic [DEPTH:0]      hit_chain;

  // Take a request whenever the output register is empty or being drained.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // Saturate capacity at the number of cells.
  assign limit     = (CMP_W'(cap_r) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_r);
  assign can_ins   = CMP_W'(fill_r) < limit;
  assign not_empty = fill_r != '0;

  // Broadcast the command; enables are gated so a rejected request leaves the row alone.
  always_comb begin
    cmd          = '0;
    cmd.handle   = in_chan.handle;
    cmd.fill     = fill_r;
    cmd.ins_en   = accept && (in_chan.mode == MODE_INSERT) && can_ins;
    cmd.shift_en = accept && (in_chan.mode == MODE_FETCH) && not_empty;
    cmd.rem_en   = accept && (in_chan.mode == MODE_REMOVE);
  end

  // Row of cells; the hit flag ripples from head to tail.
  assign hit_chain[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == DEPTH - 1) begin : g_last
      assign cell_nbr[g] = '0;
    end else begin : g_mid
      assign cell_nbr[g] = cell_data[g+1];
    end

    bqr_cell u_cell (
      .clk    (clk),
      .cmd_i  (cmd),
      .idx_i  (IDX_W'(g)),
      .nbr_i  (cell_nbr[g]),
      .hit_i  (hit_chain[g]),
      .data_o (cell_data[g]),
      .hit_o  (hit_chain[g+1])
    );
  end

  assign found = hit_chain[DEPTH];

  // Result and new fill for the request on the channel.
  always_comb begin
    status_nxt  = ST_OK;
    fetched_nxt = '0;
    fill_nxt    = fill_r;
    unique case (in_chan.mode)
      MODE_INSERT: begin
        if (can_ins) begin
          fill_nxt = fill_r + FILL_W'(1);
        end else begin
          status_nxt = ST_FULL;
        end
      end
      MODE_FETCH: begin
        if (not_empty) begin
          fetched_nxt = cell_data[0];
          fill_nxt    = fill_r - FILL_W'(1);
        end else begin
          status_nxt = ST_EMPTY;
        end
      end
      MODE_REMOVE: begin
        if (found) begin
          fill_nxt = fill_r - FILL_W'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      default: begin
        // unused code: hold everything, report ok
        status_nxt = ST_OK;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (accept) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r  <= status_nxt;
      out_fetched_r <= fetched_nxt;
      out_fill_r    <= fill_nxt;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.status  = out_status_r;
  assign out_chan.fetched = out_fetched_r;
  assign out_chan.fill    = out_fill_r;

endmodule

// File: rtl/bqr_checker.sv
`include "bounded_queue_with_remove_defines.svh"

module bqr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    out_status,
  input logic [bqr_pkg::HANDLE_W-1:0]  out_fetched,
  input logic [bqr_pkg::FILL_W-1:0]    out_fill
);
  import bqr_pkg::*;

  logic [2+HANDLE_W+FILL_W-1:0] out_payload;

  assign out_payload = {out_status, out_fetched, out_fill};

  // A stalled result holds.
  `BQR_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_payload))
  // Only a successful fetch carries a non-zero handle.
  `BQR_ASSERT_IMP(a_fetch_ok, out_valid && (out_fetched != '0), out_status == ST_OK)
  // Empty is reported only with nothing held.
  `BQR_ASSERT_IMP(a_empty_fill, out_valid && (out_status == ST_EMPTY), out_fill == '0)
  // Fill never passes the number of cells.
  `BQR_ASSERT_IMP(a_fill_max, out_valid, out_fill <= FILL_W'(DEPTH))

endmodule

bind bounded_queue_with_remove bqr_checker u_bqr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_status  (out_chan.status),
  .out_fetched (out_chan.fetched),
  .out_fill    (out_chan.fill)
);
